>>> rtl/assert_macros.svh
// Assertion macros used by the RTL that checks itself.
// No dependencies; each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define DBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define DBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition that must hold at every edge out of reset
`define DBA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

>>> rtl/dba_pkg.sv
// Shared types, constants and the glyph table of the drunken-bishop walker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dba_pkg;

  localparam int DEF_GRID_WIDTH  = 17;
  localparam int DEF_GRID_HEIGHT = 9;

  localparam int         CNT_W       = 4;
  localparam logic [7:0] START_RESET = 8'd76;
  localparam logic [3:0] COUNT_MAX   = 4'd14;

  localparam logic [7:0] GLYPH_BLANK = 8'h20; // ' '
  localparam logic [7:0] GLYPH_START = 8'h53; // 'S'
  localparam logic [7:0] GLYPH_END   = 8'h45; // 'E'

  typedef enum logic [1:0] {
    CMD_MOVE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_code_t;

  // Controller to datapath
  typedef struct packed {
    logic load_start; // latch effective start, reset sweep address
    logic sweep;      // zero one cell, advance sweep
    logic rd_bishop;  // read count of the bishop's cell
    logic rd_cell;    // read count of the requested cell
    logic wr_inc;     // write back incremented count and step the bishop
    logic load_res;   // load the result register
  } dba_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;
  } dba_sts_t;

  function automatic logic [7:0] count_glyph(input logic [3:0] count);
    logic [7:0] g;
    unique case (count)
      4'd0:    g = 8'h20; // ' '
      4'd1:    g = 8'h2E; // '.'
      4'd2:    g = 8'h6F; // 'o'
      4'd3:    g = 8'h2B; // '+'
      4'd4:    g = 8'h3D; // '='
      4'd5:    g = 8'h2A; // '*'
      4'd6:    g = 8'h42; // 'B'
      4'd7:    g = 8'h4F; // 'O'
      4'd8:    g = 8'h58; // 'X'
      4'd9:    g = 8'h40; // '@'
      4'd10:   g = 8'h25; // '%'
      4'd11:   g = 8'h26; // '&'
      4'd12:   g = 8'h23; // '#'
      4'd13:   g = 8'h2F; // '/'
      default: g = 8'h5E; // '^', saturated
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dba_cmd_if.sv
// Command channel: valid/ready handshake carrying one command item.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface dba_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [1:0] direction;
  logic [7:0] cell_index;

  modport source (output valid, command, direction, cell_index, input ready);
  modport sink   (input valid, command, direction, cell_index, output ready);
endinterface

`default_nettype wire

>>> rtl/dba_res_if.sv
// Result channel: valid/ready handshake carrying one cell report item.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface dba_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] glyph;
  logic [3:0] visit_count;
  logic [7:0] bishop_cell;

  modport source (output valid, glyph, visit_count, bishop_cell, input ready);
  modport sink   (input valid, glyph, visit_count, bishop_cell, output ready);
endinterface

`default_nettype wire

>>> rtl/dba_ctrl.sv
// Controller of the drunken-bishop walker: sequences sweep, move and read.
// Depends on dba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dba_ctrl
  import dba_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  input  wire logic [1:0] cmd_code,
  output logic            cmd_ready,
  output logic            res_valid,
  input  wire logic       res_ready,
  input  wire dba_sts_t   sts,
  output dba_ctl_t        ctl
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_SWEEP,
    ST_IDLE,
    ST_MOVE_WB,
    ST_READ_WB
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   out_free;

  assign cmd_ready = (state == ST_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign out_free  = !res_valid || res_ready;

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      ST_INIT: begin
        ctl.load_start = 1'b1;
        state_next     = ST_SWEEP;
      end
      ST_SWEEP: begin
        ctl.sweep = 1'b1;
        if (sts.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_code)
            CMD_MOVE: begin
              ctl.rd_bishop = 1'b1;
              state_next    = ST_MOVE_WB;
            end
            CMD_READ: begin
              ctl.rd_cell = 1'b1;
              state_next  = ST_READ_WB;
            end
            CMD_CLEAR: begin
              ctl.load_start = 1'b1;
              state_next     = ST_SWEEP;
            end
            default: state_next = ST_IDLE; // unused code: drop
          endcase
        end
      end
      ST_MOVE_WB: begin
        ctl.wr_inc = 1'b1;
        state_next = ST_IDLE;
      end
      ST_READ_WB: begin
        if (out_free) begin
          ctl.load_res = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_res) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/dba_datapath.sv
// Datapath of the drunken-bishop walker: count memory, bishop position,
// start register and result register. Depends on dba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dba_datapath
  import dba_pkg::*;
#(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  input  wire logic [1:0] direction,
  input  wire logic [7:0] cell_index,
  input  wire dba_ctl_t   ctl,
  output dba_sts_t        sts,
  output logic [7:0]      glyph,
  output logic [3:0]      visit_count,
  output logic [7:0]      bishop_cell
);

  localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
  localparam int POS_W      = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(GRID_HEIGHT);
  localparam int COL_W      = $clog2(GRID_WIDTH);
  localparam int CMP_W      = (POS_W > 8) ? POS_W : 8;

  logic [CNT_W-1:0] mem [CELL_COUNT];

  logic [7:0]       start_cell;
  logic [POS_W-1:0] eff_start;
  logic [CMP_W-1:0] start_ext;
  logic [CMP_W-1:0] cell_ext;
  logic             cell_in_range;
  logic [POS_W-1:0] cell_pos;

  logic [POS_W-1:0] bishop_pos;
  logic [ROW_W-1:0] bishop_row;
  logic [COL_W-1:0] bishop_col;
  logic [ROW_W-1:0] row_next;
  logic [COL_W-1:0] col_next;
  logic [1:0]       dir_q;

  logic [POS_W-1:0] sweep_addr;
  logic [POS_W-1:0] norm_rem;
  logic [ROW_W-1:0] norm_row;

  logic [CNT_W-1:0] rd_data;
  logic [POS_W-1:0] rd_cell_q;
  logic             rd_in_range_q;
  logic             rd_en;
  logic [POS_W-1:0] rd_addr;
  logic             wr_en;
  logic [POS_W-1:0] wr_addr;
  logic [CNT_W-1:0] wr_data;
  logic [CNT_W-1:0] count_inc;
  logic [7:0]       glyph_next;

  // Start register saturates to the last cell when out of range
  assign start_ext = CMP_W'(start_cell);
  assign eff_start = (start_ext > CMP_W'(CELL_COUNT - 1)) ?
                     POS_W'(CELL_COUNT - 1) : POS_W'(start_ext);

  assign cell_ext      = CMP_W'(cell_index);
  assign cell_in_range = (cell_ext < CMP_W'(CELL_COUNT));
  assign cell_pos      = POS_W'(cell_ext);

  assign sts.sweep_last = (sweep_addr == POS_W'(CELL_COUNT - 1));

  // Clamped diagonal step, using the direction held from the move item
  always_comb begin
    col_next = bishop_col;
    row_next = bishop_row;
    if (dir_q[0]) begin
      if (bishop_col < COL_W'(GRID_WIDTH - 1)) col_next = bishop_col + 1'b1;
    end else if (bishop_col != '0) begin
      col_next = bishop_col - 1'b1;
    end
    if (dir_q[1]) begin
      if (bishop_row < ROW_W'(GRID_HEIGHT - 1)) row_next = bishop_row + 1'b1;
    end else if (bishop_row != '0) begin
      row_next = bishop_row - 1'b1;
    end
  end

  assign count_inc = (rd_data >= COUNT_MAX) ? rd_data : rd_data + 1'b1;

  assign rd_en   = ctl.rd_bishop || (ctl.rd_cell && cell_in_range);
  assign rd_addr = ctl.rd_bishop ? bishop_pos : cell_pos;
  assign wr_en   = ctl.sweep || ctl.wr_inc;
  assign wr_addr = ctl.sweep ? sweep_addr : bishop_pos;
  assign wr_data = ctl.sweep ? '0 : count_inc;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
    if (ctl.rd_bishop) dir_q <= direction;
    if (ctl.rd_cell) begin
      rd_cell_q     <= cell_pos;
      rd_in_range_q <= cell_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_cell <= START_RESET;
    end else if (cfg_we) begin
      start_cell <= cfg_data;
    end
  end

  // Position: linear index plus row and column. On restart the start index
  // is split into row and column by one subtraction per sweep cycle.
  always_ff @(posedge clk) begin
    if (ctl.load_start) begin
      sweep_addr <= '0;
      bishop_pos <= eff_start;
      norm_rem   <= eff_start;
      norm_row   <= '0;
    end else if (ctl.sweep) begin
      sweep_addr <= sweep_addr + 1'b1;
      if (norm_rem >= POS_W'(GRID_WIDTH)) begin
        norm_rem <= norm_rem - POS_W'(GRID_WIDTH);
        norm_row <= norm_row + 1'b1;
      end
      if (sts.sweep_last) begin
        bishop_row <= norm_row;
        bishop_col <= COL_W'(norm_rem);
      end
    end else if (ctl.wr_inc) begin
      bishop_row <= row_next;
      bishop_col <= col_next;
      bishop_pos <= POS_W'(row_next) * POS_W'(GRID_WIDTH) + POS_W'(col_next);
    end
  end

  always_comb begin
    if (!rd_in_range_q) begin
      glyph_next = GLYPH_BLANK;
    end else if (rd_cell_q == bishop_pos) begin
      glyph_next = GLYPH_END;
    end else if (rd_cell_q == eff_start) begin
      glyph_next = GLYPH_START;
    end else begin
      glyph_next = count_glyph(rd_data);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_res) begin
      glyph       <= glyph_next;
      visit_count <= rd_in_range_q ? rd_data : '0;
      bishop_cell <= 8'(bishop_pos);
    end
  end

endmodule

`default_nettype wire

>>> rtl/drunken_bishop_art_walker.sv
// Top level of the drunken-bishop walker: joins controller and datapath to
// the command and result channels. Depends on dba_pkg, dba_cmd_if,
// dba_res_if, dba_ctrl, dba_datapath and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Drunken-bishop fingerprint art on a GRID_WIDTH by GRID_HEIGHT grid, cells
// numbered row * GRID_WIDTH + column. Each command item is taken on the cmd
// channel; only a read gives an item on the res channel. A move adds one to
// the visit count of the bishop's cell (saturating at 14), then steps one
// cell diagonally, clamped at the walls. A read reports the cell's glyph
// ('E' for the bishop's cell, else 'S' for the start cell, else the glyph of
// its count), its count and the bishop's cell; an index beyond the grid reads
// as blank with count zero. A clear zeroes all counts and puts the bishop on
// the start cell; command code 3 is taken and dropped. The counts live in a
// single memory with one registered read port, so a move reads the count and
// then writes it back, and a read waits in its write-back state for the result
// register to drain. A clear zeroes one cell per cycle; the same clearing pass
// runs after reset, and cmd.ready stays low until it is done.
// The start_cell register (cfg_data, written when cfg_we is high, reset 76)
// saturates to the last cell; writing it does not move the bishop until the
// next clear or reset. Write it only while the block is idle.
module drunken_bishop_art_walker
  import dba_pkg::*;
#(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  dba_cmd_if.sink         cmd,
  dba_res_if.source       res
);

  dba_ctl_t ctl;
  dba_sts_t sts;

  // Sequence sweep, move and read; hold the result valid flag
  dba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_code  (cmd.command),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Count memory, bishop position, start register and result payload
  dba_datapath #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .direction   (cmd.direction),
    .cell_index  (cmd.cell_index),
    .ctl         (ctl),
    .sts         (sts),
    .glyph       (res.glyph),
    .visit_count (res.visit_count),
    .bishop_cell (res.bishop_cell)
  );

  // Never overwrite a result that is still waiting
  `DBA_ASSERT_NOW(a_no_overwrite, ctl.load_res, !res.valid || res.ready, "result overwritten")
  // At most one datapath command per cycle
  `DBA_ASSERT_ALWAYS(a_one_op, $onehot0({ctl.load_start, ctl.sweep, ctl.rd_bishop | ctl.rd_cell, ctl.wr_inc, ctl.load_res}), "conflicting datapath commands")
  // A clear blocks new items while the sweep runs
  `DBA_ASSERT_NEXT(a_clear_blocks, cmd.valid && cmd.ready && (cmd.command == CMD_CLEAR), !cmd.ready, "item taken during clear")
  // A move write-back follows its read directly
  `DBA_ASSERT_NEXT(a_move_wb, ctl.rd_bishop, ctl.wr_inc && !cmd.ready, "move write-back missing")

endmodule

`default_nettype wire
